>>> rtl/lsrc_pkg.sv
package lsrc_pkg;

	// Fraction bits of the clipping parameter t.
	localparam int T_FRAC = 16;

	// Number of rectangle boundaries.
	localparam int NUM_BND = 4;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_X_MIN  = 2'd0,
		REG_Y_MIN  = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_t;

	// Classification of one boundary, handed from the front end to the back end.
	typedef struct packed {
		logic kill;   // the segment is rejected by this boundary
		logic act;    // the ratio takes part in the entry or exit choice
		logic enter;  // entering boundary (p < 0), else leaving
		logic sat;    // numerator >= |p|: the ratio is clamped to one
	} bnd_t;

endpackage

>>> rtl/lsrc_fifo.sv
module lsrc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	// DEPTH is a power of two, so the pointers wrap on their own.
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == (AW + 1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

>>> rtl/lsrc_front.sv
module lsrc_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic signed [COORD_BITS-1:0]            x_start,
	input  logic signed [COORD_BITS-1:0]            y_start,
	input  logic signed [COORD_BITS-1:0]            x_end,
	input  logic signed [COORD_BITS-1:0]            y_end,
	input  logic signed [COORD_BITS-1:0]            xmin,
	input  logic signed [COORD_BITS-1:0]            ymin,
	input  logic        [COORD_BITS-2:0]            wid,
	input  logic        [COORD_BITS-2:0]            hgt,
	input  logic                                    mq_full,
	output logic                                    cls_push,
	output logic signed [COORD_BITS-1:0]            x1,
	output logic signed [COORD_BITS-1:0]            y1,
	output logic signed [COORD_BITS:0]              dx,
	output logic signed [COORD_BITS:0]              dy,
	output logic [lsrc_pkg::NUM_BND-1:0][COORD_BITS-1:0] num,
	output logic [lsrc_pkg::NUM_BND-1:0][COORD_BITS-1:0] den,
	output lsrc_pkg::bnd_t [lsrc_pkg::NUM_BND-1:0]  bnd
);

	localparam int C = COORD_BITS;
	localparam int W = COORD_BITS + 3;
	localparam int NB = lsrc_pkg::NUM_BND;

	logic                v_s1;
	logic signed [C-1:0] x1_s1;
	logic signed [C-1:0] y1_s1;
	logic signed [C-1:0] x2_s1;
	logic signed [C-1:0] y2_s1;

	logic signed [W-1:0] dx_w;
	logic signed [W-1:0] dy_w;
	logic signed [W-1:0] p [NB];
	logic signed [W-1:0] q [NB];
	logic signed [W-1:0] n;
	logic signed [W-1:0] ap;
	logic                pz;
	logic                pneg;

	assign full     = v_s1 && mq_full;
	assign cls_push = v_s1 && !mq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!full) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			x1_s1 <= x_start;
			y1_s1 <= y_start;
			x2_s1 <= x_end;
			y2_s1 <= y_end;
		end
	end

	// The four boundaries: left, right, top and bottom.
	always_comb begin
		dx_w = W'(x2_s1) - W'(x1_s1);
		dy_w = W'(y2_s1) - W'(y1_s1);
		p[0] = -dx_w;
		p[1] = dx_w;
		p[2] = -dy_w;
		p[3] = dy_w;
		q[0] = W'(x1_s1) - W'(xmin);
		q[1] = W'(xmin) + signed'(W'(wid)) - W'(x1_s1);
		q[2] = W'(y1_s1) - W'(ymin);
		q[3] = W'(ymin) + signed'(W'(hgt)) - W'(y1_s1);
	end

	// The ratio of a boundary is q/p. It is recast as n/|p| with n = q or -q so that a
	// useful ratio is never negative; an entering ratio below zero is dropped, and a
	// leaving ratio below zero makes the segment invisible.
	always_comb begin
		n    = '0;
		ap   = '0;
		pz   = 1'b0;
		pneg = 1'b0;
		for (int l = 0; l < NB; l++) begin
			pz   = (p[l] == '0);
			pneg = p[l][W-1];
			n    = pneg ? -q[l] : q[l];
			ap   = pneg ? -p[l] : p[l];
			bnd[l].enter = pneg;
			if (pz) begin
				bnd[l].kill = q[l][W-1];
				bnd[l].act  = 1'b0;
			end else begin
				bnd[l].kill = !pneg && n[W-1];
				bnd[l].act  = !n[W-1];
			end
			bnd[l].sat = (n >= ap);
			num[l] = n[C-1:0];
			den[l] = ap[C-1:0];
		end
	end

	assign x1 = x1_s1;
	assign y1 = y1_s1;
	assign dx = dx_w[C:0];
	assign dy = dy_w[C:0];

endmodule

>>> rtl/lsrc_back.sv
module lsrc_back #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    mq_empty,
	output logic                                    mq_pop,
	input  logic signed [COORD_BITS-1:0]            x1,
	input  logic signed [COORD_BITS-1:0]            y1,
	input  logic signed [COORD_BITS:0]              dx,
	input  logic signed [COORD_BITS:0]              dy,
	input  logic [lsrc_pkg::NUM_BND-1:0][COORD_BITS-1:0] num,
	input  logic [lsrc_pkg::NUM_BND-1:0][COORD_BITS-1:0] den,
	input  lsrc_pkg::bnd_t [lsrc_pkg::NUM_BND-1:0]  bnd,
	input  logic                                    oq_full,
	output logic                                    oq_push,
	output logic                                    vis,
	output logic signed [COORD_BITS+FRAC_BITS:0]    cxs,
	output logic signed [COORD_BITS+FRAC_BITS:0]    cys,
	output logic signed [COORD_BITS+FRAC_BITS:0]    cxe,
	output logic signed [COORD_BITS+FRAC_BITS:0]    cye
);

	localparam int C  = COORD_BITS;
	localparam int T  = lsrc_pkg::T_FRAC;
	localparam int NB = lsrc_pkg::NUM_BND;
	localparam int OW = COORD_BITS + FRAC_BITS + 1;
	localparam int PW = T + COORD_BITS + 2;
	localparam int SH = T - FRAC_BITS;
	localparam logic [T:0] T_ONE = {1'b1, {T{1'b0}}};

	logic en;

	// Divider stages: one quotient bit per stage and boundary.
	logic [T:1]                  dvld_s;
	logic [NB-1:0][C-1:0]        rem_s [1:T];
	logic [NB-1:0][T-1:0]        quo_s [1:T];
	logic [NB-1:0][C-1:0]        den_s [1:T];
	lsrc_pkg::bnd_t [NB-1:0]     bnd_s [1:T];
	logic signed [C-1:0]         x1_s  [1:T];
	logic signed [C-1:0]         y1_s  [1:T];
	logic signed [C:0]           dx_s  [1:T];
	logic signed [C:0]           dy_s  [1:T];

	logic [NB-1:0][C-1:0]        rin   [1:T];
	logic [NB-1:0][T-1:0]        qin   [1:T];
	logic [NB-1:0][C-1:0]        din   [1:T];
	logic [NB-1:0][C-1:0]        rnx   [1:T];
	logic [NB-1:0][T-1:0]        qnx   [1:T];
	logic [C:0]                  dbl;

	// Entry and exit selection stage.
	logic                        vld_sa;
	logic                        vis_sa;
	logic [T:0]                  te_sa;
	logic [T:0]                  tx_sa;
	logic signed [C-1:0]         x1_sa;
	logic signed [C-1:0]         y1_sa;
	logic signed [C:0]           dx_sa;
	logic signed [C:0]           dy_sa;
	logic [T:0]                  tl;
	logic [T:0]                  te;
	logic [T:0]                  tx;
	logic                        kill;

	// Multiplier stage.
	logic                        vld_sm;
	logic                        vis_sm;
	logic signed [C-1:0]         x1_sm;
	logic signed [C-1:0]         y1_sm;
	logic signed [PW-1:0]        pxs_sm;
	logic signed [PW-1:0]        pys_sm;
	logic signed [PW-1:0]        pxe_sm;
	logic signed [PW-1:0]        pye_sm;
	logic signed [OW-1:0]        bx;
	logic signed [OW-1:0]        by;

	// The whole back end moves together; it stops only when a finished transaction
	// cannot enter the output queue.
	assign en      = !oq_full || !vld_sm;
	assign mq_pop  = en && !mq_empty;
	assign oq_push = vld_sm && !oq_full;

	always_comb begin
		dbl    = '0;
		rin[1] = num;
		qin[1] = '0;
		din[1] = den;
		for (int k = 2; k <= T; k++) begin
			rin[k] = rem_s[k-1];
			qin[k] = quo_s[k-1];
			din[k] = den_s[k-1];
		end
		for (int k = 1; k <= T; k++) begin
			for (int l = 0; l < NB; l++) begin
				dbl = {rin[k][l], 1'b0};
				if (dbl >= {1'b0, din[k][l]}) begin
					rnx[k][l] = C'(dbl - {1'b0, din[k][l]});
					qnx[k][l] = {qin[k][l][T-2:0], 1'b1};
				end else begin
					rnx[k][l] = dbl[C-1:0];
					qnx[k][l] = {qin[k][l][T-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s <= '0;
			vld_sa <= 1'b0;
			vld_sm <= 1'b0;
		end else if (en) begin
			dvld_s <= {dvld_s[T-1:1], !mq_empty};
			vld_sa <= dvld_s[T];
			vld_sm <= vld_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= T; k++) begin
				rem_s[k] <= rnx[k];
				quo_s[k] <= qnx[k];
				den_s[k] <= din[k];
			end
			bnd_s[1] <= bnd;
			x1_s[1]  <= x1;
			y1_s[1]  <= y1;
			dx_s[1]  <= dx;
			dy_s[1]  <= dy;
			for (int k = 2; k <= T; k++) begin
				bnd_s[k] <= bnd_s[k-1];
				x1_s[k]  <= x1_s[k-1];
				y1_s[k]  <= y1_s[k-1];
				dx_s[k]  <= dx_s[k-1];
				dy_s[k]  <= dy_s[k-1];
			end
		end
	end

	always_comb begin
		te   = '0;
		tx   = T_ONE;
		kill = 1'b0;
		tl   = '0;
		for (int l = 0; l < NB; l++) begin
			tl = bnd_s[T][l].sat ? T_ONE : {1'b0, quo_s[T][l]};
			kill = kill || bnd_s[T][l].kill;
			if (bnd_s[T][l].act && bnd_s[T][l].enter && (tl > te)) begin
				te = tl;
			end
			if (bnd_s[T][l].act && !bnd_s[T][l].enter && (tl < tx)) begin
				tx = tl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_sa <= !kill && (te < tx);
			te_sa  <= te;
			tx_sa  <= tx;
			x1_sa  <= x1_s[T];
			y1_sa  <= y1_s[T];
			dx_sa  <= dx_s[T];
			dy_sa  <= dy_s[T];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_sm <= vis_sa;
			x1_sm  <= x1_sa;
			y1_sm  <= y1_sa;
			pxs_sm <= $signed({1'b0, te_sa}) * dx_sa;
			pys_sm <= $signed({1'b0, te_sa}) * dy_sa;
			pxe_sm <= $signed({1'b0, tx_sa}) * dx_sa;
			pye_sm <= $signed({1'b0, tx_sa}) * dy_sa;
		end
	end

	// The arithmetic shift floors the scaled product.
	always_comb begin
		bx  = OW'(x1_sm) <<< FRAC_BITS;
		by  = OW'(y1_sm) <<< FRAC_BITS;
		vis = vis_sm;
		cxs = vis_sm ? bx + OW'(pxs_sm >>> SH) : '0;
		cys = vis_sm ? by + OW'(pys_sm >>> SH) : '0;
		cxe = vis_sm ? bx + OW'(pxe_sm >>> SH) : '0;
		cye = vis_sm ? by + OW'(pye_sm >>> SH) : '0;
	end

	a_vis_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sa && vis_sa |-> te_sa < tx_sa)
		else $error("visible segment with entry not before exit");

	a_exit_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sa |-> tx_sa <= T_ONE)
		else $error("exit parameter above one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sm && oq_full |=> vld_sm && $stable(pxe_sm) && $stable(vis_sm))
		else $error("stalled result changed");

endmodule

>>> rtl/line_segment_rect_clipper_top.sv
// Liang-Barsky clipper for integer line segments against an axis-aligned rectangle.
//
// Segments enter through a queue-like port: a transaction completes at a rising edge with
// push high and full low. Results leave the same way: the oldest result sits on the
// result ports while empty is low and is taken at an edge with pop high. One result
// comes back for every segment, in order; an invisible segment gives visible low and
// all clipped coordinates zero.
// The rectangle is set through wr_en, wr_index and wr_data and must only be changed
// while the block is idle. Reset loads a 640 by 480 rectangle at the origin and empties
// every queue; the pipeline valid bits are cleared at once.
// On its way from an accepted segment to its result on the outputs, a segment passes
// one input register, the boundary queue, one restoring divider stage per parameter
// bit, the entry/exit selection, the multiplier and the output queue. Throughput is
// one segment per cycle while nothing stalls, set by the fully pipelined divider.
// When the receiver stops popping, the output queue fills, the back end halts, the
// boundary queue between the two halves fills and finally full rises; nothing is lost.
module line_segment_rect_clipper_top #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_index,
	input  logic [COORD_BITS-1:0]                wr_data,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [COORD_BITS-1:0]         x_start,
	input  logic signed [COORD_BITS-1:0]         y_start,
	input  logic signed [COORD_BITS-1:0]         x_end,
	input  logic signed [COORD_BITS-1:0]         y_end,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 visible,
	output logic signed [COORD_BITS+FRAC_BITS:0] clipped_x_start,
	output logic signed [COORD_BITS+FRAC_BITS:0] clipped_y_start,
	output logic signed [COORD_BITS+FRAC_BITS:0] clipped_x_end,
	output logic signed [COORD_BITS+FRAC_BITS:0] clipped_y_end
);

	localparam int C   = COORD_BITS;
	localparam int NB  = lsrc_pkg::NUM_BND;
	localparam int OW  = COORD_BITS + FRAC_BITS + 1;
	// Boundary queue entry: endpoint, deltas, and per boundary a numerator, a divisor
	// and the four classification flags.
	localparam int MQW = 2 * C + 2 * (C + 1) + NB * (2 * C + $bits(lsrc_pkg::bnd_t));
	localparam int OQW = 1 + 4 * OW;

	// Rectangle registers.
	logic signed [C-1:0] xmin_q;
	logic signed [C-1:0] ymin_q;
	logic [C-2:0]        wid_q;
	logic [C-2:0]        hgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xmin_q <= '0;
			ymin_q <= '0;
			wid_q  <= (C - 1)'(640);
			hgt_q  <= (C - 1)'(480);
		end else if (wr_en) begin
			unique case (lsrc_pkg::cfg_reg_t'(wr_index))
				lsrc_pkg::REG_X_MIN:  xmin_q <= wr_data;
				lsrc_pkg::REG_Y_MIN:  ymin_q <= wr_data;
				lsrc_pkg::REG_WIDTH:  wid_q  <= wr_data[C-2:0];
				lsrc_pkg::REG_HEIGHT: hgt_q  <= wr_data[C-2:0];
				default: ;
			endcase
		end
	end

	// Front end to boundary queue.
	logic                           cls_push;
	logic                           mq_full;
	logic                           mq_empty;
	logic                           mq_pop;
	logic [MQW-1:0]                 mq_wdata;
	logic [MQW-1:0]                 mq_rdata;
	logic signed [C-1:0]            f_x1;
	logic signed [C-1:0]            f_y1;
	logic signed [C:0]              f_dx;
	logic signed [C:0]              f_dy;
	logic [NB-1:0][C-1:0]           f_num;
	logic [NB-1:0][C-1:0]           f_den;
	lsrc_pkg::bnd_t [NB-1:0]        f_bnd;
	logic signed [C-1:0]            b_x1;
	logic signed [C-1:0]            b_y1;
	logic signed [C:0]              b_dx;
	logic signed [C:0]              b_dy;
	logic [NB-1:0][C-1:0]           b_num;
	logic [NB-1:0][C-1:0]           b_den;
	lsrc_pkg::bnd_t [NB-1:0]        b_bnd;

	lsrc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.xmin     (xmin_q),
		.ymin     (ymin_q),
		.wid      (wid_q),
		.hgt      (hgt_q),
		.mq_full  (mq_full),
		.cls_push (cls_push),
		.x1       (f_x1),
		.y1       (f_y1),
		.dx       (f_dx),
		.dy       (f_dy),
		.num      (f_num),
		.den      (f_den),
		.bnd      (f_bnd)
	);

	assign mq_wdata = {f_x1, f_y1, f_dx, f_dy, f_num, f_den, f_bnd};
	assign {b_x1, b_y1, b_dx, b_dy, b_num, b_den, b_bnd} = mq_rdata;

	// A short queue lets the front end keep taking segments while the back end stalls.
	lsrc_fifo #(
		.WIDTH(MQW),
		.DEPTH(4)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cls_push),
		.wdata  (mq_wdata),
		.full   (mq_full),
		.rd     (mq_pop),
		.rdata  (mq_rdata),
		.empty  (mq_empty)
	);

	// Back end to output queue.
	logic                 oq_push;
	logic                 oq_full;
	logic [OQW-1:0]       oq_wdata;
	logic [OQW-1:0]       oq_rdata;
	logic                 r_vis;
	logic signed [OW-1:0] r_cxs;
	logic signed [OW-1:0] r_cys;
	logic signed [OW-1:0] r_cxe;
	logic signed [OW-1:0] r_cye;

	lsrc_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mq_empty (mq_empty),
		.mq_pop   (mq_pop),
		.x1       (b_x1),
		.y1       (b_y1),
		.dx       (b_dx),
		.dy       (b_dy),
		.num      (b_num),
		.den      (b_den),
		.bnd      (b_bnd),
		.oq_full  (oq_full),
		.oq_push  (oq_push),
		.vis      (r_vis),
		.cxs      (r_cxs),
		.cys      (r_cys),
		.cxe      (r_cxe),
		.cye      (r_cye)
	);

	assign oq_wdata = {r_vis, r_cxs, r_cys, r_cxe, r_cye};

	// The output queue parts the pipeline from the receiver.
	lsrc_fifo #(
		.WIDTH(OQW),
		.DEPTH(2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (oq_push),
		.wdata  (oq_wdata),
		.full   (oq_full),
		.rd     (pop),
		.rdata  (oq_rdata),
		.empty  (empty)
	);

	assign {visible, clipped_x_start, clipped_y_start, clipped_x_end, clipped_y_end} = oq_rdata;

endmodule

>>> sim/lsrc_checker.sv
module lsrc_checker #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_index,
	input  logic [COORD_BITS-1:0]                wr_data,
	input  logic                                 push,
	input  logic                                 full,
	input  logic signed [COORD_BITS-1:0]         x_start,
	input  logic signed [COORD_BITS-1:0]         y_start,
	input  logic signed [COORD_BITS-1:0]         x_end,
	input  logic signed [COORD_BITS-1:0]         y_end,
	input  logic                                 empty,
	input  logic                                 pop,
	input  logic                                 visible,
	input  logic signed [COORD_BITS+FRAC_BITS:0] clipped_x_start,
	input  logic signed [COORD_BITS+FRAC_BITS:0] clipped_y_start,
	input  logic signed [COORD_BITS+FRAC_BITS:0] clipped_x_end,
	input  logic signed [COORD_BITS+FRAC_BITS:0] clipped_y_end,
	output int                                   fail_count,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OW = COORD_BITS + FRAC_BITS + 1;

	typedef struct packed {
		logic          vis;
		logic [OW-1:0] xs;
		logic [OW-1:0] ys;
		logic [OW-1:0] xe;
		logic [OW-1:0] ye;
	} clip_res_t;

	logic signed [COORD_BITS-1:0] rect_x0, rect_y0;
	logic [COORD_BITS-2:0] rect_w, rect_h;
	clip_res_t clip_queue[$];

	function automatic longint floor_div_pow2(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-v + ((longint'(1) << s) - 1)) >>> s);
	endfunction

	function automatic clip_res_t clip_segment(longint x1, longint y1, longint x2, longint y2);
		longint xmin, ymin, dx, dy, t, t_in, t_out;
		longint p[4], q[4];
		logic killed;
		clip_res_t r;
		xmin = rect_x0;
		ymin = rect_y0;
		dx = x2 - x1;
		dy = y2 - y1;
		p[0] = -dx; q[0] = x1 - xmin;
		p[1] = dx;  q[1] = xmin + rect_w - x1;
		p[2] = -dy; q[2] = y1 - ymin;
		p[3] = dy;  q[3] = ymin + rect_h - y1;
		t_in = 0;
		t_out = longint'(1) << lsrc_pkg::T_FRAC;
		killed = 0;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			if (p[i] == 0) begin
				if (q[i] < 0)
					killed = 1;
			end else begin
				// SystemVerilog division truncates toward zero, as required.
				t = (q[i] * (longint'(1) << lsrc_pkg::T_FRAC)) / p[i];
				if (p[i] < 0 && t > t_in)
					t_in = t;
				if (p[i] > 0 && t < t_out)
					t_out = t;
			end
		end
		if (!killed && t_in < t_out) begin
			r.vis = 1;
			r.xs = OW'(x1 * (1 << FRAC_BITS)
				+ floor_div_pow2(t_in * dx, lsrc_pkg::T_FRAC - FRAC_BITS));
			r.ys = OW'(y1 * (1 << FRAC_BITS)
				+ floor_div_pow2(t_in * dy, lsrc_pkg::T_FRAC - FRAC_BITS));
			r.xe = OW'(x1 * (1 << FRAC_BITS)
				+ floor_div_pow2(t_out * dx, lsrc_pkg::T_FRAC - FRAC_BITS));
			r.ye = OW'(y1 * (1 << FRAC_BITS)
				+ floor_div_pow2(t_out * dy, lsrc_pkg::T_FRAC - FRAC_BITS));
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		clip_res_t want;
		if (!arst_n) begin
			rect_x0 <= '0;
			rect_y0 <= '0;
			rect_w <= (COORD_BITS - 1)'(640);
			rect_h <= (COORD_BITS - 1)'(480);
			fail_count = 0;
			clip_queue.delete();
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (clip_queue.size() == 0) begin
					$error("unexpected result: nothing waiting");
					fail_count++;
				end else begin
					want = clip_queue.pop_front();
					if (visible !== want.vis) begin
						$error("visible: expected %0d, got %0d", want.vis, visible);
						fail_count++;
					end
					if (clipped_x_start !== want.xs) begin
						$error("clipped_x_start: expected %0d, got %0d",
							$signed(want.xs), clipped_x_start);
						fail_count++;
					end
					if (clipped_y_start !== want.ys) begin
						$error("clipped_y_start: expected %0d, got %0d",
							$signed(want.ys), clipped_y_start);
						fail_count++;
					end
					if (clipped_x_end !== want.xe) begin
						$error("clipped_x_end: expected %0d, got %0d",
							$signed(want.xe), clipped_x_end);
						fail_count++;
					end
					if (clipped_y_end !== want.ye) begin
						$error("clipped_y_end: expected %0d, got %0d",
							$signed(want.ye), clipped_y_end);
						fail_count++;
					end
				end
			end
			if (push && !full)
				clip_queue.insert(clip_queue.size(),
					clip_segment(x_start, y_start, x_end, y_end));
			if (wr_en) begin
				case (lsrc_pkg::cfg_reg_t'(wr_index))
					lsrc_pkg::REG_X_MIN:  rect_x0 <= wr_data;
					lsrc_pkg::REG_Y_MIN:  rect_y0 <= wr_data;
					lsrc_pkg::REG_WIDTH:  rect_w <= wr_data[COORD_BITS-2:0];
					lsrc_pkg::REG_HEIGHT: rect_h <= wr_data[COORD_BITS-2:0];
					default: ;
				endcase
			end
			pending = clip_queue.size();
		end
	end

endmodule

>>> sim/tb_line_segment_rect_clipper_top.sv
// Testbench top: it drives segments and rectangle settings into the clipper, pops
// results with random stalls, and leaves prediction and comparison to lsrc_checker.
module tb_line_segment_rect_clipper_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 16;
	localparam int FB = 8;
	localparam int LATENCY = lsrc_pkg::T_FRAC + 4;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [CB-1:0] wr_data;
	logic push, full, empty, pop;
	logic signed [CB-1:0] x_start, y_start, x_end, y_end;
	logic visible;
	logic signed [CB+FB:0] clipped_x_start, clipped_y_start, clipped_x_end, clipped_y_end;
	int fail_count, pending;
	longint cycles;
	// Set while the receiver is to be held off for a long stretch.
	bit hold_pop;

	line_segment_rect_clipper_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (.*);

	lsrc_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run ends long before this.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver side: pops with random stalls, or not at all while hold_pop is set.
	initial begin
		int g;
		pop = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pop) begin
				pop <= 0;
			end else begin
				g = gap_len();
				if (g == 0) begin
					pop <= 1;
				end else begin
					pop <= 0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// Offers one segment and holds it until the transaction completes. Push stays
	// high afterwards; whoever idles the input next lowers it.
	task automatic send_segment(int xs, int ys, int xe, int ye);
		x_start <= CB'(xs);
		y_start <= CB'(ys);
		x_end <= CB'(xe);
		y_end <= CB'(ye);
		push <= 1;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	// Segment with idle gaps before it on random occasions.
	task automatic send_gapped(int xs, int ys, int xe, int ye);
		int g;
		g = $urandom_range(0, 3) == 0 ? gap_len() : 0;
		if (g > 0)
			push <= 0;
		repeat (g) @(negedge clk);
		send_segment(xs, ys, xe, ye);
	endtask

	// Waits until every expected result has come and the pipeline has gone quiet.
	task automatic drain();
		push <= 0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(lsrc_pkg::cfg_reg_t idx, int val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= CB'(val);
		@(negedge clk);
	endtask

	task automatic set_rect(int x0, int y0, int w, int h);
		write_reg(lsrc_pkg::REG_X_MIN, x0);
		write_reg(lsrc_pkg::REG_Y_MIN, y0);
		write_reg(lsrc_pkg::REG_WIDTH, w);
		write_reg(lsrc_pkg::REG_HEIGHT, h);
		wr_en <= 0;
	endtask

	// Coordinate within the rectangle's span or 20 beyond it most of the time, anywhere otherwise.
	function automatic logic [CB-1:0] pick_coord(int lo, int span);
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return CB'($urandom);
		if (r < 3) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		return CB'(lo + $signed($urandom_range(0, span + 40)) - 20);
	endfunction

	initial begin
		int lo_x, lo_y, sw, sh;
		logic [CB-1:0] a, b;
		push = 0;
		wr_en = 0;
		wr_index = lsrc_pkg::REG_X_MIN;
		wr_data = '0;
		x_start = '0;
		y_start = '0;
		x_end = '0;
		y_end = '0;
		hold_pop = 0;
		arst_n = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part with the reset rectangle 640 by 480 at the origin.
		send_segment(-10, 100, 700, 200);       // crosses both vertical edges
		send_segment(100, -50, 200, 600);       // crosses both horizontal edges
		send_segment(10, 10, 100, 100);         // fully inside
		send_segment(50, 50, 50, 50);           // a point inside
		send_segment(-5, 50, -5, 50);           // a point outside
		send_segment(0, 0, 640, 480);           // corner to corner
		send_segment(-100, 10, -100, 400);      // vertical, left of the rectangle
		send_segment(700, 10, 800, 10);         // horizontal, right and outside
		send_segment(-100, -100, -10, -20);     // outside, diagonal
		send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_segment(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_segment(16'hffff, 16'hffff, 16'h0000, 16'h0000);
		send_segment(640, 240, 700, 240);       // touches the right edge only
		send_segment(300, 10, 100, 400);        // runs backwards
		send_segment(640, 480, 0, 0);
		drain();

		// Extreme rectangles: zero size, then the largest at the most negative origin.
		set_rect(100, 100, 0, 0);
		send_segment(100, 100, 100, 100);
		send_segment(0, 0, 200, 200);
		send_segment(0, 100, 200, 100);
		drain();
		set_rect(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_segment(16'h7fff, 0, 16'h8000, 5);
		send_segment(-1, -1, -1, -1);
		drain();

		// Random phases, each under its own rectangle.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin lo_x = 32767; lo_y = 32767; sw = 32767; sh = 32767; end
				1: begin lo_x = -20; lo_y = 30; sw = 5; sh = 3; end
				default: begin
					lo_x = $signed(16'($urandom));
					lo_y = $signed(16'($urandom_range(0, 65535)));
					sw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
						: $urandom_range(0, 600);
					sh = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
						: $urandom_range(0, 600);
				end
			endcase
			set_rect(lo_x, lo_y, sw, sh);
			for (int k = 0; k < 200; k++) begin
				// Halfway through the third phase the receiver stalls for a long
				// stretch while segments keep coming, so the block fills and pushes back.
				if (phase == 2 && k == 100) begin
					fork
						begin
							hold_pop = 1;
							repeat (300) @(negedge clk);
							hold_pop = 0;
						end
					join_none
				end
				a = pick_coord(lo_x, sw);
				b = pick_coord(lo_y, sh);
				case ($urandom_range(0, 5))
					0: send_gapped(a, b, a, b);
					1: send_gapped(a, b, pick_coord(lo_x, sw), b);
					2: send_gapped(a, b, a, pick_coord(lo_y, sh));
					default: send_gapped(a, b, pick_coord(lo_x, sw), pick_coord(lo_y, sh));
				endcase
				// In the fifth phase the sender waits once, midway, for every outstanding result.
				if (phase == 4 && k == 100) begin
					push <= 0;
					while (pending != 0) @(negedge clk);
				end
			end
			drain();
		end

		// Back to the reset rectangle for a final check that it is restored by writes.
		set_rect(0, 0, 640, 480);
		send_segment(-10, 100, 700, 200);
		push <= 0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
